FILE: design/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Command encoding between front and back, back-end state codes, field widths.
// No dependencies.
package tcw_pkg;

  localparam int unsigned ModeW    = 2;
  localparam int unsigned CharW    = 8;
  localparam int unsigned ArgW     = 8;
  localparam int unsigned CellW    = 16;
  localparam int unsigned AttrW    = 8;
  localparam int unsigned CurColW  = 7;
  localparam int unsigned CurRowW  = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CharW-1:0] NewlineCode = 8'h0A;
  localparam logic [AttrW-1:0] AttrReset   = 8'd15;

  typedef enum logic [ModeW-1:0] {
    MODE_PRINT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_SET   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATTR   = 2'd0,
    CFG_OUT_ON = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_PRINT   = 3'd1,
    OP_NEWLINE = 3'd2,
    OP_READ    = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_SET     = 3'd5
  } op_e;

  // row/col are already clamped into the screen
  typedef struct packed {
    op_e              op;
    logic [CharW-1:0] chr;
    logic [ArgW-1:0]  row;
    logic [ArgW-1:0]  col;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT  = 3'd0,
    ST_RUN   = 3'd1,
    ST_READ  = 3'd2,
    ST_BLANK = 3'd3,
    ST_CLEAR = 3'd4
  } bstate_e;

endpackage

FILE: design/tcw_front.sv
// Front end of the text console writer: input handshake, mode decode and
// argument clamping into a command word. Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ModeW-1:0]        mode_i,
  input  logic [CharW-1:0]        char_code_i,
  input  logic signed [ArgW-1:0]  row_arg_i,
  input  logic signed [ArgW-1:0]  col_arg_i,
  input  logic                    output_on_i,
  input  logic                    q_full_i,
  input  logic                    init_busy_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  localparam logic [ArgW:0] ColLim = (ArgW+1)'(COLUMNS);
  localparam logic [ArgW:0] RowLim = (ArgW+1)'(ROWS);

  function automatic logic [ArgW-1:0] clamp_arg(logic signed [ArgW-1:0] a,
                                                logic [ArgW:0] lim);
    logic [ArgW:0] v;
    logic [ArgW:0] top;
    v   = {1'b0, a};
    top = lim - 1'b1;
    if (a[ArgW-1]) return '0;
    else if (v >= lim) return top[ArgW-1:0];
    else return v[ArgW-1:0];
  endfunction

  // no beats taken while the back end is wiping the screen after reset
  assign in_stall_o = q_full_i | init_busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    cmd_o.chr = char_code_i;
    cmd_o.row = clamp_arg(row_arg_i, RowLim);
    cmd_o.col = clamp_arg(col_arg_i, ColLim);
    unique case (mode_e'(mode_i))
      MODE_PRINT: begin
        if (!output_on_i) cmd_o.op = OP_NOP;
        else if (char_code_i == NewlineCode) cmd_o.op = OP_NEWLINE;
        else cmd_o.op = OP_PRINT;
      end
      MODE_READ:  cmd_o.op = OP_READ;
      MODE_CLEAR: cmd_o.op = output_on_i ? OP_CLEAR : OP_NOP;
      MODE_SET:   cmd_o.op = OP_SET;
      default:    cmd_o.op = OP_NOP;
    endcase
  end

endmodule

FILE: design/tcw_fifo.sv
// Two-entry command queue between front and back ends.
// Depends on tcw_pkg for the command word.
module tcw_fifo import tcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule

FILE: design/tcw_back.sv
// Back end of the text console writer: cursor, screen memory, scroll and
// clear sweeps, result register. Depends on tcw_pkg.
module tcw_back import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [AttrW-1:0]   attr_i,
  input  logic               empty_i,
  input  cmd_t               cmd_i,
  output logic               pop_o,
  output logic               init_busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CellW-1:0]   cell_value_o,
  output logic [CurColW-1:0] cursor_col_o,
  output logic [CurRowW-1:0] cursor_row_o,
  output logic               did_scroll_o
);

  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned Cells = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(Cells);

  localparam logic [CW-1:0] LastCol  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LastRow  = RW'(ROWS - 1);
  localparam logic [AW-1:0] LastCell = AW'(Cells - 1);
  localparam logic [AW-1:0] RowSpan  = AW'(COLUMNS - 1);

  // screen rows rotate: logical row r sits in physical row (r + base) mod ROWS
  function automatic logic [RW-1:0] phys_row(logic [RW-1:0] r, logic [RW-1:0] b);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= (RW+1)'(ROWS)) s = s - (RW+1)'(ROWS);
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] pr, logic [CW-1:0] c);
    logic [AW-1:0] p;
    p = AW'(pr) * AW'(COLUMNS);
    return p + AW'(c);
  endfunction

  bstate_e       state_q, state_d;
  logic [CW-1:0] x_q, x_d;
  logic [RW-1:0] y_q, y_d;
  logic [RW-1:0] base_q, base_d;
  logic [AW-1:0] walk_q, walk_d;
  logic [AW-1:0] walk_end_q, walk_end_d;
  logic          out_valid_q, out_valid_d;

  logic [CellW-1:0]   cell_q, cell_d;
  logic [CurColW-1:0] col_q, col_d;
  logic [CurRowW-1:0] row_q, row_d;
  logic               scroll_q, scroll_d;

  logic [CellW-1:0] mem_q [Cells];
  logic [CellW-1:0] rdata_q;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [CellW-1:0] wdata;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    row_base;
  logic [RW-1:0]    base_next;
  logic             out_free;
  logic             load;
  logic             nl;
  logic [CW+CurColW-1:0] col_wide;
  logic [RW+CurRowW-1:0] row_wide;

  assign cur_addr  = cell_addr(phys_row(y_q, base_q), x_q);
  assign rd_addr   = cell_addr(phys_row(cmd_i.row[RW-1:0], base_q), cmd_i.col[CW-1:0]);
  assign row_base  = cell_addr(base_q, '0);
  assign base_next = (base_q == LastRow) ? '0 : base_q + 1'b1;
  assign out_free  = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    base_d     = base_q;
    walk_d     = walk_q;
    walk_end_d = walk_end_q;
    pop_o      = 1'b0;
    we         = 1'b0;
    waddr      = walk_q;
    wdata      = '0;
    load       = 1'b0;
    nl         = 1'b0;
    cell_d     = '0;
    scroll_d   = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        we = 1'b1;
        if (walk_q == walk_end_q) state_d = ST_RUN;
        else walk_d = walk_q + 1'b1;
      end
      ST_RUN: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_PRINT: begin
              we    = 1'b1;
              waddr = cur_addr;
              wdata = {attr_i, cmd_i.chr};
              if (x_q != LastCol) begin
                x_d  = x_q + 1'b1;
                load = 1'b1;
              end else begin
                nl = 1'b1;
              end
            end
            OP_NEWLINE: nl = 1'b1;
            OP_READ:    state_d = ST_READ;
            OP_CLEAR: begin
              x_d        = '0;
              y_d        = '0;
              base_d     = '0;
              walk_d     = '0;
              walk_end_d = LastCell;
              state_d    = ST_CLEAR;
            end
            OP_SET: begin
              x_d  = cmd_i.col[CW-1:0];
              y_d  = cmd_i.row[RW-1:0];
              load = 1'b1;
            end
            default: load = 1'b1;
          endcase
          if (nl) begin
            x_d = '0;
            if (y_q != LastRow) begin
              y_d  = y_q + 1'b1;
              load = 1'b1;
            end else begin
              // the old top row becomes the blank bottom row
              base_d     = base_next;
              walk_d     = row_base;
              walk_end_d = row_base + RowSpan;
              state_d    = ST_BLANK;
            end
          end
        end
      end
      ST_READ: begin
        load    = 1'b1;
        cell_d  = rdata_q;
        state_d = ST_RUN;
      end
      ST_BLANK, ST_CLEAR: begin
        we = 1'b1;
        if (walk_q == walk_end_q) begin
          load     = 1'b1;
          scroll_d = state_q == ST_BLANK;
          state_d  = ST_RUN;
        end else begin
          walk_d = walk_q + 1'b1;
        end
      end
      default: state_d = ST_INIT;
    endcase

    col_wide = {{CurColW{1'b0}}, x_d};
    row_wide = {{CurRowW{1'b0}}, y_d};
    col_d    = col_wide[CurColW-1:0];
    row_d    = row_wide[CurRowW-1:0];

    if (load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      x_q         <= '0;
      y_q         <= '0;
      base_q      <= '0;
      walk_q      <= '0;
      walk_end_q  <= LastCell;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      base_q      <= base_d;
      walk_q      <= walk_d;
      walk_end_q  <= walk_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cell_q   <= cell_d;
      col_q    <= col_d;
      row_q    <= row_d;
      scroll_q <= scroll_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[rd_addr];
  end

  assign init_busy_o  = state_q == ST_INIT;
  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_q;
  assign cursor_col_o = col_q;
  assign cursor_row_o = row_q;
  assign did_scroll_o = scroll_q;

endmodule

FILE: design/text_console_writer_unit.sv
// Top level of the text console writer: configuration registers, front end,
// command queue and back end. Depends on tcw_pkg, tcw_front, tcw_fifo, tcw_back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | input     | in_valid_i/in_stall_o | mode_i char_code_i row_arg_i col_arg_i
//   out     | output    | out_valid_o/out_stall_i | cell_value_o cursor_col_o cursor_row_o
//           |           |                       | did_scroll_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i cfg_data_i
//
// Print, newline without scroll, set cursor and no-op are done in ST_RUN; a read also
// passes through ST_READ (the read port of the screen memory is registered).
// A scroll blanks one rotated row in ST_BLANK. Clear sweeps the memory in ST_CLEAR,
// one cell written per cycle.
// After reset ST_INIT wipes the screen memory; in_stall_o stays high meanwhile.
// A two-entry queue takes beats while the back end works or the result is stalled.
module text_console_writer_unit import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ModeW-1:0]       mode_i,
  input  logic [CharW-1:0]       char_code_i,
  input  logic signed [ArgW-1:0] row_arg_i,
  input  logic signed [ArgW-1:0] col_arg_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CellW-1:0]       cell_value_o,
  output logic [CurColW-1:0]     cursor_col_o,
  output logic [CurRowW-1:0]     cursor_row_o,
  output logic                   did_scroll_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  logic [AttrW-1:0] attr_q, attr_d;
  logic             out_on_q, out_on_d;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  logic init_busy;
  cmd_t front_cmd;
  cmd_t head_cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    attr_d   = attr_q;
    out_on_d = out_on_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ATTR:   attr_d   = cfg_data_i[AttrW-1:0];
        CFG_OUT_ON: out_on_d = cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q   <= AttrReset;
      out_on_q <= 1'b1;
    end else begin
      attr_q   <= attr_d;
      out_on_q <= out_on_d;
    end
  end

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .row_arg_i   (row_arg_i),
    .col_arg_i   (col_arg_i),
    .output_on_i (out_on_q),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  tcw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .attr_i       (attr_q),
    .empty_i      (q_empty),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .init_busy_o  (init_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_value_o (cell_value_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .did_scroll_o (did_scroll_o)
  );

endmodule

FILE: design/tcw_checker.sv
// Port-level checks for text_console_writer_unit, attached by bind.
// Depends on tcw_pkg and the top level's ports.
module tcw_checker import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [CellW-1:0]       cell_value_o,
  input logic [CurColW-1:0]     cursor_col_o,
  input logic [CurRowW-1:0]     cursor_row_o,
  input logic                   did_scroll_o
);

  localparam logic [CurRowW-1:0] ScrollRow = CurRowW'(ROWS - 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cell_value_o) && $stable(cursor_col_o)
      && $stable(cursor_row_o) && $stable(did_scroll_o))
    else $error("result payload changed while stalled");

  // a scroll leaves the cursor at the start of the last line
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && did_scroll_o |-> cursor_col_o == '0 && cursor_row_o == ScrollRow)
    else $error("cursor not at start of last line after scroll");

  // only reads return cell data, and reads never scroll
  a_scroll_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && did_scroll_o |-> cell_value_o == '0)
    else $error("scroll result carries cell data");

  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (COLUMNS > 128 || int'(cursor_col_o) < COLUMNS)
      && (ROWS > 32 || int'(cursor_row_o) < ROWS))
    else $error("cursor outside the screen");

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cell_value_o (cell_value_o),
  .cursor_col_o (cursor_col_o),
  .cursor_row_o (cursor_row_o),
  .did_scroll_o (did_scroll_o)
);

FILE: tb/text_console_writer_unit_test.sv
// Self-checking testbench for text_console_writer_unit: a shadow copy of the screen
// predicts every result beat, and random idling on both channels varies the timing.
// Depends on tcw_pkg and the design sources.
`timescale 1ns / 1ps

module text_console_writer_unit_test;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned CELLS       = ROWS * COLUMNS;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam int unsigned LONG_HOLD   = 300;
  // worst back-end job is a full clear; leave room for it before touching registers
  localparam int unsigned SETTLE      = CELLS + COLUMNS + 16;
  localparam int unsigned LIMIT       = 4 * ((PHASES * PHASE_ITEMS + 40) * (32 + CELLS + 4)
                                        + (PHASES + 2) * SETTLE + LONG_HOLD + CELLS);

  typedef struct {
    logic [CellW-1:0]   cell_val;
    logic [CurColW-1:0] col;
    logic [CurRowW-1:0] row;
    logic               scroll;
  } screen_reply_t;

  class console_shadow;
    logic [CellW-1:0] screen [CELLS];
    int unsigned      cur_x;
    int unsigned      cur_y;
    logic [AttrW-1:0] attr;
    logic             out_on;
    screen_reply_t    replies_due [$];
    int unsigned      errors;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cur_x  = 0;
      cur_y  = 0;
      attr   = AttrReset;
      out_on = 1'b1;
      errors = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [CfgDataW-1:0] value);
      if (idx == CFG_ATTR) attr = value[AttrW-1:0];
      else if (idx == CFG_OUT_ON) out_on = value[0];
    endfunction

    function int unsigned fit(logic signed [ArgW-1:0] v, int unsigned lim);
      if (v < 0) return 0;
      if (int'(v) >= int'(lim)) return lim - 1;
      return int'(v);
    endfunction

    function logic line_feed();
      cur_x = 0;
      cur_y++;
      if (cur_y < ROWS) return 1'b0;
      for (int unsigned i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int unsigned i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen[i] = '0;
      cur_y = ROWS - 1;
      return 1'b1;
    endfunction

    function void take_command(logic [ModeW-1:0] mode, logic [CharW-1:0] chr,
                               logic signed [ArgW-1:0] row, logic signed [ArgW-1:0] col);
      screen_reply_t want;
      want.cell_val = '0;
      want.scroll   = 1'b0;
      case (mode)
        MODE_PRINT: begin
          if (out_on) begin
            if (chr == NewlineCode) begin
              want.scroll = line_feed();
            end else begin
              screen[cur_y * COLUMNS + cur_x] = {attr, chr};
              cur_x++;
              if (cur_x >= COLUMNS) want.scroll = line_feed();
            end
          end
        end
        MODE_READ: want.cell_val = screen[fit(row, ROWS) * COLUMNS + fit(col, COLUMNS)];
        MODE_CLEAR: begin
          if (out_on) begin
            foreach (screen[i]) screen[i] = '0;
            cur_x = 0;
            cur_y = 0;
          end
        end
        default: begin
          cur_y = fit(row, ROWS);
          cur_x = fit(col, COLUMNS);
        end
      endcase
      want.col = cur_x[CurColW-1:0];
      want.row = cur_y[CurRowW-1:0];
      replies_due.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("ERROR at %0t: %s", $time, what);
    endtask

    task check_reply(logic [CellW-1:0] cell_val, logic [CurColW-1:0] col,
                     logic [CurRowW-1:0] row, logic scroll);
      screen_reply_t want;
      if (replies_due.size() == 0) begin
        report("result beat with no command outstanding");
        return;
      end
      want = replies_due.pop_front();
      if (cell_val !== want.cell_val)
        report($sformatf("cell_value %h, want %h", cell_val, want.cell_val));
      if (col !== want.col) report($sformatf("cursor_col %0d, want %0d", col, want.col));
      if (row !== want.row) report($sformatf("cursor_row %0d, want %0d", row, want.row));
      if (scroll !== want.scroll)
        report($sformatf("did_scroll %b, want %b", scroll, want.scroll));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [ModeW-1:0]       mode_i;
  logic [CharW-1:0]       char_code_i;
  logic signed [ArgW-1:0] row_arg_i;
  logic signed [ArgW-1:0] col_arg_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [CellW-1:0]       cell_value_o;
  logic [CurColW-1:0]     cursor_col_o;
  logic [CurRowW-1:0]     cursor_row_o;
  logic                   did_scroll_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgDataW-1:0]    cfg_data_i;

  console_shadow shadow;
  int            send_calm = 0;
  int            recv_calm = 0;
  logic          hold_wanted = 1'b0;
  logic          hold_done = 1'b0;

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .char_code_i (char_code_i),
    .row_arg_i   (row_arg_i),
    .col_arg_i   (col_arg_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_value_o(cell_value_o),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .did_scroll_o(did_scroll_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // random idle gap before each beat, with occasional stretches of back-to-back beats
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        shadow.take_command(mode_i, char_code_i, row_arg_i, col_arg_i);
      if (out_valid_o && !out_stall_i)
        shadow.check_reply(cell_value_o, cursor_col_o, cursor_row_o, did_scroll_o);
    end
  end

  task automatic send_command(input logic [ModeW-1:0] m, input logic [CharW-1:0] c,
                              input logic signed [ArgW-1:0] r,
                              input logic signed [ArgW-1:0] k);
    int gap;
    gap = draw_gap(send_calm);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    char_code_i <= c;
    row_arg_i   <= r;
    col_arg_i   <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [ModeW-1:0]       m;
    logic [CharW-1:0]       c;
    logic signed [ArgW-1:0] r;
    logic signed [ArgW-1:0] k;
    int                     pick;
    pick = $urandom_range(0, 99);
    c = CharW'($urandom);
    r = ArgW'($urandom);
    k = ArgW'($urandom);
    if (pick < 58) begin
      m = MODE_PRINT;
      if ($urandom_range(0, 6) == 0) c = NewlineCode;
    end else if (pick < 78) begin
      m = MODE_READ;
    end else if (pick < 96) begin
      m = MODE_SET;
    end else begin
      m = MODE_CLEAR;
    end
    // mostly on screen; the corner case drives wraps and scrolls
    case ($urandom_range(0, 3))
      0, 1: begin
        r = ArgW'($urandom_range(0, ROWS - 1));
        k = ArgW'($urandom_range(0, COLUMNS - 1));
      end
      2: begin
        r = ArgW'(ROWS - 1 - $urandom_range(0, 1));
        k = ArgW'(COLUMNS - 1 - $urandom_range(0, 3));
      end
      default: ;
    endcase
    send_command(m, c, r, k);
  endtask

  task automatic program_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow.set_register(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : receiver
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_wanted && !hold_done) begin
        gap = LONG_HOLD;
        hold_done = 1'b1;
      end else begin
        gap = draw_gap(recv_calm);
      end
      if (gap > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [AttrW-1:0] attr;
    logic             on;
    shadow      = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_PRINT;
    char_code_i = '0;
    row_arg_i   = '0;
    col_arg_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ATTR;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    program_register(CFG_ATTR, 8'hFF);
    program_register(CFG_OUT_ON, 8'd1);

    send_command(MODE_PRINT, 8'h00, 8'sd0, 8'sd0);
    send_command(MODE_PRINT, 8'hFF, 8'sd0, 8'sd0);
    send_command(MODE_PRINT, 8'h41, 8'sh7F, 8'sh80);
    send_command(MODE_READ, 8'h00, 8'sd0, 8'sd0);
    send_command(MODE_READ, 8'hFF, 8'sd0, 8'sd1);
    send_command(MODE_PRINT, NewlineCode, 8'sd0, 8'sd0);
    send_command(MODE_SET, 8'h00, 8'sh80, 8'sh80);
    send_command(MODE_READ, 8'h00, 8'shFF, 8'sh7F);
    send_command(MODE_SET, 8'h00, 8'sh7F, 8'sh7F);
    // last cell: wrap pushes the cursor off the bottom
    send_command(MODE_PRINT, 8'h5A, 8'sd0, 8'sd0);
    send_command(MODE_READ, 8'h00, 8'sd23, 8'sd79);
    send_command(MODE_PRINT, NewlineCode, 8'sd0, 8'sd0);
    send_command(MODE_SET, 8'h00, 8'sd24, 8'sd78);
    send_command(MODE_PRINT, 8'h7F, 8'sd0, 8'sd0);
    send_command(MODE_PRINT, 8'h80, 8'sd0, 8'sd0);
    send_command(MODE_READ, 8'h00, 8'sd24, 8'sd0);
    send_command(MODE_READ, 8'h00, 8'sh7F, 8'sh80);
    send_command(MODE_READ, 8'h00, 8'sd23, 8'sd78);
    send_command(MODE_READ, 8'h00, 8'sd25, 8'sd80);
    send_command(MODE_SET, 8'hFF, 8'sd5, 8'sd3);
    send_command(MODE_PRINT, 8'h0B, 8'sh80, 8'sh7F);
    send_command(MODE_CLEAR, 8'hFF, 8'sh7F, 8'sh7F);
    send_command(MODE_READ, 8'h00, 8'sd5, 8'sd3);
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: attr = 8'h00;
        1: attr = 8'hFF;
        4: attr = AttrReset;
        6: attr = 8'h80;
        default: attr = AttrW'($urandom);
      endcase
      on = (p != 3);
      program_register(CFG_ATTR, attr);
      program_register(CFG_OUT_ON, {7'd0, on});
      if (!on) begin
        // with output off, print and clear must leave screen and cursor alone
        send_command(MODE_SET, 8'h00, 8'sd10, 8'sd10);
        send_command(MODE_PRINT, 8'h51, 8'sd0, 8'sd0);
        send_command(MODE_PRINT, NewlineCode, 8'sd0, 8'sd0);
        send_command(MODE_CLEAR, 8'h00, 8'sd0, 8'sd0);
        send_command(MODE_READ, 8'h00, 8'sd0, 8'sd0);
      end
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 40) hold_wanted = 1'b1;
        send_random();
      end
      drain();
    end

    if (shadow.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
